[sv/pmds_pkg.sv]
// shared types and fixed field widths for the pll multiplier / divider search
// no dependencies; imported by pll_mul_div_search_core
package pmds_pkg;

	localparam int REF_W  = 28;
	localparam int TGT_W  = 30;
	localparam int MULT_W = 11;
	localparam int DIVR_W = 7;
	localparam int ERR_W  = 30;
	localparam int SEL_W  = 19;
	// bit counter for the restoring divider, counts 0 .. REF_W-1
	localparam int BCNT_W = 5;
	localparam int SEL_SHIFT = 8;

	localparam logic [REF_W-1:0] REF_RESET = REF_W'(24000000);

	typedef logic [REF_W-1:0]  ref_t;
	typedef logic [TGT_W-1:0]  tgt_t;
	typedef logic [MULT_W-1:0] mult_t;
	typedef logic [DIVR_W-1:0] divr_t;
	typedef logic [ERR_W-1:0]  err_t;
	typedef logic [SEL_W-1:0]  sel_t;
	typedef logic [BCNT_W-1:0] bcnt_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SRCH = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

[sv/pll_mul_div_search_core.sv]
// pll multiplier / divider search: quotient table build, then a pipelined pair scan
// depends on pmds_pkg
//
//  channel   dir  handshake           payload
//  cfg       in   cfg_we              cfg_wdata (ref_clock_hz)
//  in        in   in_valid/in_stall   target_freq
//  out       out  out_valid/out_stall multiplier, divider, error_hz, select_word, found
//
// one transaction fills the quotient table through a one-bit-per-cycle restoring divider,
// then scans multiplier / divider pairs through one shared multiplier, one pair per cycle;
// an exact match ends the scan early.
// in_stall is high from accept until the result is loaded into the output register.
// the output register holds a result while out_stall is high; a new transaction may run
// meanwhile. arst_n clears control state and sets ref_clock_hz to 24000000.
module pll_mul_div_search_core
	import pmds_pkg::*;
#(
	parameter int MUL_LIMIT = 2048,
	parameter int DIV_LIMIT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  ref_t        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  tgt_t        target_freq,
	output logic        out_valid,
	input  logic        out_stall,
	output mult_t       multiplier,
	output divr_t       divider,
	output err_t        error_hz,
	output sel_t        select_word,
	output logic        found
);

	localparam int MW = $clog2(MUL_LIMIT);
	localparam int DW = $clog2(DIV_LIMIT);
	localparam int PW = REF_W + MW;
	localparam int EW = (PW > TGT_W) ? PW : TGT_W;
	localparam int SW = MW + SEL_SHIFT + 1;
	localparam logic [MW-1:0] M_LAST = MW'(MUL_LIMIT - 1);
	localparam logic [DW-1:0] D_LAST = DW'(DIV_LIMIT - 1);
	localparam logic [MW-1:0] M_ONE  = MW'(1);
	localparam logic [DW-1:0] D_ONE  = DW'(1);
	localparam bcnt_t         B_LAST = BCNT_W'(REF_W - 1);

	state_t state_q;
	ref_t   ref_q;
	tgt_t   target_q;

	// divider unit
	logic [DW-1:0] dd_q;
	bcnt_t         bcnt_q;
	ref_t          dvd_q;
	ref_t          quo_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          ge;
	ref_t          quo_next;

	// quotient table
	ref_t          qmem [DIV_LIMIT];

	// scan pipeline
	logic          issue_q;
	logic [MW-1:0] im_q;
	logic [DW-1:0] id_q;
	logic          rd_en;
	logic          v_s1, v_s2;
	logic [MW-1:0] m_s1, m_s2;
	logic [DW-1:0] d_s1, d_s2;
	ref_t          q_s1;
	logic [PW-1:0] prod_s2;
	logic [EW-1:0] prod_ext, tgt_ext, diff;
	logic          better;

	err_t          best_err_q;
	logic [MW-1:0] best_m_q;
	logic [DW-1:0] best_d_q;

	logic          load_out;
	logic          best_found;
	logic [SW-1:0] sel_wide;

	mult_t  multiplier_q;
	divr_t  divider_q;
	err_t   error_hz_q;
	sel_t   select_word_q;
	logic   found_q;
	logic   out_valid_q;

	assign trial    = {rem_q, dvd_q[REF_W-1]};
	assign ge       = (trial >= {1'b0, dd_q});
	assign quo_next = {quo_q[REF_W-2:0], ge};

	assign rd_en    = (state_q == ST_SRCH) && issue_q && (best_err_q != '0);

	assign prod_ext = EW'(prod_s2);
	assign tgt_ext  = EW'(target_q);
	assign diff     = (prod_ext > tgt_ext) ? (prod_ext - tgt_ext) : (tgt_ext - prod_ext);
	assign better   = v_s2 && (diff < EW'(best_err_q));

	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign best_found = (best_d_q != '0);
	assign sel_wide   = (SW'(best_m_q) << SEL_SHIFT) | SW'(best_d_q - D_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bcnt_q == B_LAST && dd_q == D_LAST) begin
						state_q <= ST_SRCH;
						issue_q <= 1'b1;
					end
				end
				ST_SRCH: begin
					if (rd_en && im_q == M_LAST && id_q == D_LAST) begin
						issue_q <= 1'b0;
					end
					if (!rd_en && !v_s1 && !v_s2) begin
						state_q <= ST_DONE;
						issue_q <= 1'b0;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			target_q <= target_freq;
			dd_q     <= D_ONE;
			bcnt_q   <= '0;
			dvd_q    <= ref_q;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (state_q == ST_DIV) begin
			if (bcnt_q == B_LAST) begin
				qmem[dd_q] <= quo_next;
				dd_q       <= dd_q + D_ONE;
				bcnt_q     <= '0;
				dvd_q      <= ref_q;
				rem_q      <= '0;
				quo_q      <= '0;
			end else begin
				bcnt_q <= bcnt_q + 1'b1;
				dvd_q  <= {dvd_q[REF_W-2:0], 1'b0};
				rem_q  <= ge ? DW'(trial - {1'b0, dd_q}) : DW'(trial);
				quo_q  <= quo_next;
			end
		end
	end

	// pair scan: table read, multiply, compare
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			im_q <= M_ONE;
			id_q <= D_ONE;
		end else if (rd_en) begin
			if (id_q == D_LAST) begin
				id_q <= D_ONE;
				im_q <= im_q + M_ONE;
			end else begin
				id_q <= id_q + D_ONE;
			end
		end
		if (rd_en) begin
			q_s1 <= qmem[id_q];
		end
		m_s1    <= im_q;
		d_s1    <= id_q;
		m_s2    <= m_s1;
		d_s2    <= d_s1;
		prod_s2 <= PW'(m_s1) * PW'(q_s1);
	end

	// running best; strict compare keeps the earliest pair on ties
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			best_err_q <= target_freq;
			best_m_q   <= '0;
			best_d_q   <= '0;
		end else if (better) begin
			best_err_q <= ERR_W'(diff);
			best_m_q   <= m_s2;
			best_d_q   <= d_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q    <= best_found;
			error_hz_q <= best_err_q;
			if (best_found) begin
				multiplier_q  <= MULT_W'(best_m_q);
				divider_q     <= DIVR_W'(best_d_q);
				select_word_q <= SEL_W'(sel_wide);
			end else begin
				multiplier_q  <= '0;
				divider_q     <= '0;
				select_word_q <= '0;
			end
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign multiplier  = multiplier_q;
	assign divider     = divider_q;
	assign error_hz    = error_hz_q;
	assign select_word = select_word_q;
	assign found       = found_q;

`ifndef SYNTH
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DIV))
		else $error("accepted transaction did not start the quotient build");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |=> (best_err_q <= $past(best_err_q)))
		else $error("best error grew during the scan");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (multiplier == '0 && divider == '0 && select_word == '0))
		else $error("result without a match carries a nonzero pair");

	a_scan_idle_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DIV) |-> (!v_s1 && !v_s2 && !rd_en))
		else $error("scan pipeline active outside the search phase");
`endif

endmodule
